[hdl/wmrb_pkg.sv]
// Package for the window mean ring buffer: sizes, FSM state type and the
// controller-to-datapath command struct. No dependencies.
package wmrb_pkg;

  // Window depth (1..64)
  localparam int unsigned DEPTH  = 5;

  // Field widths
  localparam int unsigned YearW  = 12;
  localparam int unsigned TagW   = 16;

  // Derived widths
  localparam int unsigned IdxW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW   = $clog2(DEPTH + 1);
  localparam int unsigned SumW   = $clog2(DEPTH * 4095 + 1);
  localparam int unsigned NumW   = $clog2(2 * DEPTH * 4095 + DEPTH + 1);
  localparam int unsigned DivW   = CntW + 1;
  // Quotient bits retired by the divider, one per cycle
  localparam int unsigned QuoW   = YearW;
  localparam int unsigned StepW  = $clog2(QuoW);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIVIDE,
    ST_WRITE
  } wmrb_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;  // take input beat: evict/insert, update sum and count
    logic load;    // set up divider from running sum and count
    logic step;    // one restoring-division step
    logic write;   // move result into output register
  } wmrb_cmd_t;

endpackage

[hdl/wmrb_ctrl.sv]
// Controller FSM for the window mean ring buffer.
// Depends on wmrb_pkg; drives wmrb_cmd_t to wmrb_datapath.
module wmrb_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output wmrb_pkg::wmrb_cmd_t cmd_o
);

  wmrb_pkg::wmrb_state_e          state_q, state_d;
  logic [wmrb_pkg::StepW-1:0]     step_q, step_d;
  logic                           out_valid_q, out_valid_d;
  logic                           out_free;
  logic                           last_step;

  // Output register can take a new beat
  assign out_free  = !out_valid_q || !out_stall_i;
  assign last_step = (step_q == wmrb_pkg::StepW'(wmrb_pkg::QuoW - 1));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      wmrb_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = wmrb_pkg::ST_LOAD;
      end
      wmrb_pkg::ST_LOAD: begin
        state_d = wmrb_pkg::ST_DIVIDE;
      end
      wmrb_pkg::ST_DIVIDE: begin
        if (last_step) state_d = wmrb_pkg::ST_WRITE;
      end
      wmrb_pkg::ST_WRITE: begin
        if (out_free) state_d = wmrb_pkg::ST_IDLE;
      end
      default: state_d = wmrb_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o = '0;
    case (state_q)
      wmrb_pkg::ST_IDLE:   cmd_o.accept = in_valid_i;
      wmrb_pkg::ST_LOAD:   cmd_o.load   = 1'b1;
      wmrb_pkg::ST_DIVIDE: cmd_o.step   = 1'b1;
      wmrb_pkg::ST_WRITE:  cmd_o.write  = out_free;
      default:             cmd_o        = '0;
    endcase
  end

  // Step counter and output valid
  always_comb begin
    step_d = step_q;
    if (cmd_o.load) begin
      step_d = '0;
    end else if (cmd_o.step && !last_step) begin
      step_d = step_q + 1'b1;
    end
    out_valid_d = out_valid_q;
    if (cmd_o.write) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wmrb_pkg::ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != wmrb_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[hdl/wmrb_datapath.sv]
// Datapath for the window mean ring buffer: entry stores, ring pointers,
// running sum, bit-serial divider and output register. Depends on wmrb_pkg.
module wmrb_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  wmrb_pkg::wmrb_cmd_t         cmd_i,
  input  logic [wmrb_pkg::YearW-1:0]  year_value_i,
  input  logic [wmrb_pkg::TagW-1:0]   entry_tag_i,
  output logic                        evicted_o,
  output logic [wmrb_pkg::TagW-1:0]   evicted_tag_o,
  output logic [wmrb_pkg::YearW-1:0]  mean_year_o
);

  // Entry stores, no reset: only written slots are read
  logic [wmrb_pkg::YearW-1:0] year_mem_q [wmrb_pkg::DEPTH];
  logic [wmrb_pkg::TagW-1:0]  tag_mem_q  [wmrb_pkg::DEPTH];

  logic [wmrb_pkg::IdxW-1:0]  head_q, head_d, tail_q, tail_d;
  logic [wmrb_pkg::CntW-1:0]  count_q, count_d;
  logic [wmrb_pkg::SumW-1:0]  sum_q, sum_d;
  logic                       full;

  logic                       ev_q;
  logic [wmrb_pkg::TagW-1:0]  ev_tag_q;

  logic [wmrb_pkg::DivW-1:0]  rem_q;
  logic [wmrb_pkg::QuoW-1:0]  nlo_q;
  logic [wmrb_pkg::QuoW-1:0]  quo_q;
  logic [wmrb_pkg::NumW-1:0]  num;
  logic [wmrb_pkg::DivW-1:0]  divisor;
  logic [wmrb_pkg::DivW:0]    trial;
  logic [wmrb_pkg::DivW:0]    diff;
  logic                       qbit;

  logic                        out_ev_q;
  logic [wmrb_pkg::TagW-1:0]   out_tag_q;
  logic [wmrb_pkg::YearW-1:0]  out_mean_q;

  function automatic logic [wmrb_pkg::IdxW-1:0] next_idx(
    input logic [wmrb_pkg::IdxW-1:0] idx
  );
    if (idx == wmrb_pkg::IdxW'(wmrb_pkg::DEPTH - 1)) return '0;
    return idx + 1'b1;
  endfunction

  // Ring bookkeeping on each accepted beat
  assign full = (count_q == wmrb_pkg::CntW'(wmrb_pkg::DEPTH));

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    sum_d   = sum_q;
    if (cmd_i.accept) begin
      tail_d = next_idx(tail_q);
      if (full) begin
        head_d = next_idx(head_q);
        sum_d  = sum_q - wmrb_pkg::SumW'(year_mem_q[head_q])
                       + wmrb_pkg::SumW'(year_value_i);
      end else begin
        count_d = count_q + 1'b1;
        sum_d   = sum_q + wmrb_pkg::SumW'(year_value_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      sum_q   <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      sum_q   <= sum_d;
    end
  end

  // Store write and eviction capture; head is read before the slot is overwritten
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      year_mem_q[tail_q] <= year_value_i;
      tag_mem_q[tail_q]  <= entry_tag_i;
      ev_q               <= full;
      ev_tag_q           <= full ? tag_mem_q[head_q] : '0;
    end
  end

  // Divider: (2*sum + count) / (2*count); quotient fits in QuoW bits, so the
  // upper numerator bits start out below the divisor
  assign num     = wmrb_pkg::NumW'({sum_q, 1'b0}) + wmrb_pkg::NumW'(count_q);
  assign divisor = {count_q, 1'b0};
  assign trial   = {rem_q, nlo_q[wmrb_pkg::QuoW-1]};
  assign diff    = trial - {1'b0, divisor};
  assign qbit    = (trial >= {1'b0, divisor});

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rem_q <= wmrb_pkg::DivW'(num >> wmrb_pkg::QuoW);
      nlo_q <= num[wmrb_pkg::QuoW-1:0];
      quo_q <= '0;
    end else if (cmd_i.step) begin
      rem_q <= qbit ? diff[wmrb_pkg::DivW-1:0] : trial[wmrb_pkg::DivW-1:0];
      nlo_q <= {nlo_q[wmrb_pkg::QuoW-2:0], 1'b0};
      quo_q <= {quo_q[wmrb_pkg::QuoW-2:0], qbit};
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      out_ev_q   <= ev_q;
      out_tag_q  <= ev_tag_q;
      out_mean_q <= quo_q;
    end
  end

  assign evicted_o     = out_ev_q;
  assign evicted_tag_o = out_tag_q;
  assign mean_year_o   = out_mean_q;

  // Checks
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= wmrb_pkg::CntW'(wmrb_pkg::DEPTH))
    else $error("entry count above depth");

  a_empty_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (sum_q == '0))
    else $error("running sum nonzero with empty window");

  a_ptr_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((count_q == '0) || full) |-> (head_q == tail_q))
    else $error("head and tail disagree for empty or full window");

  a_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.accept |=> (count_q != '0))
    else $error("window empty after insert");

  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (rem_q < divisor))
    else $error("divider remainder not below divisor");

endmodule

[hdl/window_mean_ring_buffer_unit.sv]
// Window mean ring buffer: keeps the last DEPTH (year, tag) beats and
// reports the rounded half-up mean of the stored years after each insert.
//
// Input channel: in_valid_i / in_stall_o with year_value_i and entry_tag_i.
// A beat is taken at a clock edge with in_valid_i high and in_stall_o low.
// Output channel: out_valid_o / out_stall_i with evicted_o, evicted_tag_o
// and mean_year_o; one output beat per input beat, in order.
// When the window is full, the oldest entry is dropped first and its tag
// is reported with evicted_o high; otherwise evicted_tag_o is 0.
// The result is built in turn: the beat is inserted, the divider is set
// up, 12 divider steps retire one quotient bit per cycle, and the quotient
// is written to the output register. The input stays stalled from a beat
// until its result is written, so no new beat is taken before that.
// A finished result waits in the output register while the next input is
// taken; if the receiver still stalls when the next result is done, the
// block holds that result and keeps in_stall_o high.
// Reset (rst_ni low, asynchronous) empties the window and clears valid.
module window_mean_ring_buffer_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [wmrb_pkg::YearW-1:0]  year_value_i,
  input  logic [wmrb_pkg::TagW-1:0]   entry_tag_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        evicted_o,
  output logic [wmrb_pkg::TagW-1:0]   evicted_tag_o,
  output logic [wmrb_pkg::YearW-1:0]  mean_year_o
);

  wmrb_pkg::wmrb_cmd_t cmd;

  wmrb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  wmrb_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .year_value_i  (year_value_i),
    .entry_tag_i   (entry_tag_i),
    .evicted_o     (evicted_o),
    .evicted_tag_o (evicted_tag_o),
    .mean_year_o   (mean_year_o)
  );

endmodule

[test/tb_window_mean_ring_buffer_unit.sv]
// Testbench for window_mean_ring_buffer_unit: directed and random beats checked
// against an in-bench sliding-window mean predictor under several handshake profiles.
// Depends on wmrb_pkg (hdl/wmrb_pkg.sv) and the unit under test.
module tb_window_mean_ring_buffer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchdogCycles = 400_000;
  localparam int unsigned SettleCycles   = 20;
  localparam int unsigned MaxReports     = 10;

  typedef logic [wmrb_pkg::IdxW-1:0] slot_t;

  // One result beat: eviction flag, dropped tag, rounded mean
  typedef struct packed {
    logic                       evicted;
    logic [wmrb_pkg::TagW-1:0]  tag;
    logic [wmrb_pkg::YearW-1:0] mean;
  } window_result_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic [wmrb_pkg::YearW-1:0]  year_value_i;
  logic [wmrb_pkg::TagW-1:0]   entry_tag_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic                        evicted_o;
  logic [wmrb_pkg::TagW-1:0]   evicted_tag_o;
  logic [wmrb_pkg::YearW-1:0]  mean_year_o;

  // Predictor copy of the window
  logic [wmrb_pkg::YearW-1:0]  win_year [wmrb_pkg::DEPTH];
  logic [wmrb_pkg::TagW-1:0]   win_tag [wmrb_pkg::DEPTH];
  slot_t                       win_head;
  slot_t                       win_tail;
  logic [wmrb_pkg::CntW-1:0]   win_fill;
  logic [wmrb_pkg::SumW-1:0]   win_sum;

  window_result_t    pending_results[$];
  int unsigned       send_idle_pct;
  int unsigned       recv_stall_pct;
  int unsigned       beats_sent;
  int unsigned       results_seen;
  int unsigned       eviction_count;
  int unsigned       mismatch_count;

  window_mean_ring_buffer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .year_value_i  (year_value_i),
    .entry_tag_i   (entry_tag_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .evicted_o     (evicted_o),
    .evicted_tag_o (evicted_tag_o),
    .mean_year_o   (mean_year_o)
  );

  // Clock
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic slot_t next_slot(input slot_t idx);
    return (idx == slot_t'(wmrb_pkg::DEPTH - 1)) ? '0 : slot_t'(idx + 1'b1);
  endfunction

  // Insert one entry into the predicted window; return the expected result beat
  function automatic window_result_t predict_insert(
    input logic [wmrb_pkg::YearW-1:0] year,
    input logic [wmrb_pkg::TagW-1:0]  tag
  );
    window_result_t            res;
    logic [wmrb_pkg::NumW-1:0] numer;
    logic [wmrb_pkg::DivW-1:0] denom;
    res = '0;
    // full window: drop the oldest entry first
    if (win_fill == wmrb_pkg::CntW'(wmrb_pkg::DEPTH)) begin
      res.evicted    = 1'b1;
      res.tag        = win_tag[win_head];
      win_sum        = win_sum - win_year[win_head];
      win_head       = next_slot(win_head);
      win_fill       = win_fill - 1'b1;
      eviction_count += 1;
    end
    win_year[win_tail] = year;
    win_tag[win_tail]  = tag;
    win_tail           = next_slot(win_tail);
    win_fill           = win_fill + 1'b1;
    win_sum            = win_sum + year;
    // half-up rounding: floor((2*sum + n) / (2*n))
    numer    = wmrb_pkg::NumW'(2 * win_sum + win_fill);
    denom    = wmrb_pkg::DivW'(2 * win_fill);
    res.mean = wmrb_pkg::YearW'(numer / denom);
    return res;
  endfunction

  // Send one beat; returns in the time step of the accepting edge
  task automatic send_item(input logic [wmrb_pkg::YearW-1:0] year,
                           input logic [wmrb_pkg::TagW-1:0]  tag);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    year_value_i <= year;
    entry_tag_i  <= tag;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(predict_insert(year, tag));
    beats_sent += 1;
  endtask

  task automatic send_random_item();
    logic [wmrb_pkg::YearW-1:0] year;
    // mix full range, low corner, high corner and realistic years
    case ($urandom_range(3))
      0:       year = wmrb_pkg::YearW'($urandom_range(4095));
      1:       year = wmrb_pkg::YearW'($urandom_range(15));
      2:       year = wmrb_pkg::YearW'($urandom_range(4095, 4080));
      default: year = wmrb_pkg::YearW'($urandom_range(2030, 1900));
    endcase
    send_item(year, wmrb_pkg::TagW'($urandom_range(16'hFFFF)));
  endtask

  // Hold valid low until every expected result has come back
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic run_random(input int unsigned count, input int unsigned idle_pct,
                            input int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_random_item();
  endtask

  // Field extremes, half-up at count two, fill-up and eviction, max and zero sums
  task automatic test_directed_extremes();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_item(12'd0,    16'h0000);
    send_item(12'd4095, 16'hFFFF);
    send_item(12'd1,    16'hAAAA);
    send_item(12'd2,    16'h5555);
    send_item(12'd4095, 16'h0F0F);
    send_item(12'd4095, 16'hF0F0);
    send_item(12'd4095, 16'h8000);
    send_item(12'd4095, 16'h0001);
    send_item(12'd4095, 16'h7FFF);
    send_item(12'd4095, 16'hFFFE);
    send_item(12'd0,    16'h1111);
    send_item(12'd0,    16'h2222);
    send_item(12'd0,    16'h3333);
    send_item(12'd0,    16'h4444);
    send_item(12'd0,    16'h5555);
    send_item(12'd1,    16'h0100);
    send_item(12'd1,    16'h0200);
    send_item(12'd1,    16'h0300);
    send_item(12'd2,    16'h0400);
    send_item(12'd2,    16'h0500);
    send_item(12'd2048, 16'hC3C3);
    send_item(12'd2047, 16'h3C3C);
  endtask

  task automatic test_back_to_back();
    run_random(270, 0, 0);
  endtask

  task automatic test_sender_gaps();
    run_random(270, 70, 0);
  endtask

  // Short bursts, each followed by a full drain with the sender paused
  task automatic test_drain_pause();
    send_idle_pct  = 0;
    recv_stall_pct = 30;
    repeat (10) begin
      repeat ($urandom_range(6, 1)) send_random_item();
      wait_for_drain();
    end
  endtask

  task automatic test_receiver_stalls();
    run_random(270, 0, 70);
  endtask

  task automatic test_both_idle();
    run_random(270, 34, 34);
  endtask

  // Result check and receiver stall
  always @(posedge clk_i) begin : result_check
    window_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen += 1;
      if (pending_results.size() == 0) begin
        mismatch_count += 1;
        if (mismatch_count <= MaxReports)
          $display("%0t: unexpected result beat evicted=%0b tag=%h mean=%0d",
                   $realtime, evicted_o, evicted_tag_o, mean_year_o);
      end else begin
        want = pending_results.pop_front();
        if (evicted_o !== want.evicted || evicted_tag_o !== want.tag ||
            mean_year_o !== want.mean) begin
          mismatch_count += 1;
          if (mismatch_count <= MaxReports)
            $display({"%0t: result %0d mismatch: evicted %0b/%0b tag %h/%h ",
                      "mean %0d/%0d (exp/act)"},
                     $realtime, results_seen, want.evicted, evicted_o, want.tag,
                     evicted_tag_o, want.mean, mean_year_o);
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog
  initial begin
    repeat (WatchdogCycles) @(posedge clk_i);
    $display("Timeout with %0d results outstanding", pending_results.size());
    $display("Regression FAIL");
    $finish;
  end

  // Main sequence
  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    year_value_i   = '0;
    entry_tag_i    = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    beats_sent     = 0;
    results_seen   = 0;
    eviction_count = 0;
    mismatch_count = 0;
    win_head       = '0;
    win_tail       = '0;
    win_fill       = '0;
    win_sum        = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_extremes();
    test_back_to_back();
    test_sender_gaps();
    test_drain_pause();
    test_receiver_stalls();
    test_both_idle();

    recv_stall_pct = 0;
    wait_for_drain();
    repeat (SettleCycles) @(posedge clk_i);

    if (pending_results.size() != 0)
      $display("%0d expected results never arrived", pending_results.size());
    $display("Sent %0d beats, checked %0d results (%0d with eviction), %0d mismatches,",
             beats_sent, results_seen, eviction_count, mismatch_count);
    $display("over back-to-back, sender-gap, drain-pause, receiver-stall and mixed profiles");
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
